/* rtl/qwhs_pkg.sv */
// shared constants and types for the quadgram word hint signature block
package qwhs_pkg;

    localparam logic [31:0] HASH_MULT  = 32'h9E37_79B9;
    localparam logic [31:0] GRAM_START = 32'h0000_0020;
    localparam int          POS_W      = 5;
    localparam int          HINT_W     = 64;
    localparam int          BITNO_W    = 6;

    typedef struct packed {
        logic             en;
        logic             use_gram;
        logic [POS_W-1:0] shamt;
    } qwhs_hash_ctl_t;

endpackage

/* rtl/qwhs_hash_unit.sv */
// shared shift and multiply unit, one hash per cycle while ctl.en is set into a result register
module qwhs_hash_unit (
    input  logic                   aclk,
    input  qwhs_pkg::qwhs_hash_ctl_t ctl,
    input  logic [31:0]            gram,
    output logic [31:0]            hash_reg
);
    import qwhs_pkg::*;

    logic [31:0] src;
    logic [31:0] shifted;
    logic [31:0] hash_next;

    always_comb begin
        src       = ctl.use_gram ? gram : hash_reg;
        shifted   = src >> ctl.shamt;
        hash_next = shifted * HASH_MULT;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            hash_reg <= hash_next;
        end
    end

endmodule

/* rtl/quadgram_word_hint_signature_core.sv */
// top level: word state, hash sequencer and output register
//
// Usage:
//   Characters of a word enter one per item on the s_ channel; s_tlast marks
//   the last character of the word. One result item leaves on the m_ channel
//   per word, at its last character: m_tdata carries the 64-bit hint and
//   m_tuser is set for words of fewer than three characters (hint zero).
//   cfg_wr_en/cfg_wr_data write the scheme mode (1 after reset); write it
//   only while the block is idle.
// Hash sequence:
//   A character passes through accept, n hashes (n from 0 to 4) and a
//   finish step: the single shared 32x32 multiplier runs one hash per cycle,
//   so a character at position two in the newer scheme takes four hashes, a
//   plain gram one. s_tready is low while a character is in work.
//   m_tvalid is registered from the finish step of the last character.
// Reset and stall:
//   aresetn (synchronous, active low) clears word state and drops m_tvalid.
//   The output register frees the input side; if a finished word finds the
//   previous result still untaken, the block holds until m_tready.
module quadgram_word_hint_signature_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tlast,   // end_of_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // hint_upper[31:0], hint_lower[63:32]
    output logic        m_tuser    // too_short
);
    import qwhs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_FINISH} state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [31:0]          gram_reg, gram_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 past_reg, past_next;
    logic [HINT_W-1:0]    hint_reg, hint_next;
    logic [POS_W-1:0]     sh_reg, sh_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic                 eow_reg, eow_next;
    logic                 short_reg, short_next;
    logic                 ovalid_reg, ovalid_next;
    logic [HINT_W-1:0]    odata_reg, odata_next;
    logic                 oshort_reg, oshort_next;

    qwhs_hash_ctl_t       hctl;
    logic [31:0]          hash;
    logic [HINT_W-1:0]    hint_marked;
    logic                 early;
    logic                 accept;
    logic                 out_free;
    logic [2:0]           n_hash;

    qwhs_hash_unit u_hash (
        .aclk     (aclk),
        .ctl      (hctl),
        .gram     (gram_reg),
        .hash_reg (hash)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign early    = !past_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = oshort_reg;

    always_comb begin
        hint_marked = hint_reg;
        if (pend_reg) begin
            hint_marked = hint_reg | ({1'b1, {(HINT_W-1){1'b0}}} >> hash[31:32-BITNO_W]);
        end
        if (early && pos_reg < POS_W'(2)) begin
            n_hash = 3'd0;
        end else if (mode_reg && early && pos_reg == POS_W'(2)) begin
            n_hash = 3'd4;
        end else if (mode_reg && early && pos_reg == POS_W'(3)) begin
            n_hash = 3'd3;
        end else begin
            n_hash = 3'd1;
        end
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = cfg_wr_en ? cfg_wr_data : mode_reg;
        gram_next   = gram_reg;
        pos_next    = pos_reg;
        past_next   = past_reg;
        hint_next   = hint_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        eow_next    = eow_reg;
        short_next  = short_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        oshort_next = oshort_reg;
        hctl.en       = 1'b0;
        hctl.use_gram = !pend_reg;
        hctl.shamt    = sh_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gram_next  = {gram_reg[23:0], s_tdata};
                    pos_next   = pos_reg + POS_W'(1);
                    sh_next    = pos_reg;
                    eow_next   = s_tlast;
                    short_next = early && pos_reg < POS_W'(2);
                    pend_next  = 1'b0;
                    if (early && pos_reg == POS_W'(3)) begin
                        past_next = 1'b1;
                    end
                    if (n_hash == 3'd0) begin
                        cnt_next   = 2'd0;
                        state_next = ST_FINISH;
                    end else begin
                        cnt_next   = 2'(n_hash - 3'd1);
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                hctl.en   = 1'b1;
                hint_next = hint_marked;
                pend_next = 1'b1;
                if (cnt_reg == 2'd0) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end
            ST_FINISH: begin
                hint_next = hint_marked;
                pend_next = 1'b0;
                if (!eow_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = {hint_marked[31:0], hint_marked[63:32]};
                    oshort_next = short_reg;
                    gram_next   = GRAM_START;
                    pos_next    = '0;
                    past_next   = 1'b0;
                    hint_next   = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= 1'b1;
            gram_reg   <= GRAM_START;
            pos_reg    <= '0;
            past_reg   <= 1'b0;
            hint_reg   <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            gram_reg   <= gram_next;
            pos_reg    <= pos_next;
            past_reg   <= past_next;
            hint_reg   <= hint_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg     <= sh_next;
        eow_reg    <= eow_next;
        short_reg  <= short_next;
        odata_reg  <= odata_next;
        oshort_reg <= oshort_next;
    end

endmodule

/* rtl/qwhs_checker.sv */
// port-level checks for the quadgram word hint signature block
module qwhs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // short words carry an empty hint
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("short word with nonzero hint");

    // full words always set at least one hint bit
    a_long_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata != 64'd0)
        else $error("full word with empty hint");

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

endmodule

bind quadgram_word_hint_signature_core qwhs_checker u_qwhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
